FILE: sv/fdtdef_pkg.sv
// ----------------------------------------------------------------------------
// fdtdef_pkg
// Shared types, register map and saturating fixed-point helpers for the
// electric field update with time filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fdtdef_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned Q_FRAC = 30;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned THETA_W = 31;
  localparam int unsigned NSTG = 11;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] ALPHA_RST = 32'sh4000_0000;

  typedef enum logic [1:0] {
    KIND_EX   = 2'd0,
    KIND_EY   = 2'd1,
    KIND_EZ   = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_TIME_STEP = 3'd0,
    REG_STEP_DX   = 3'd1,
    REG_STEP_DY   = 3'd2,
    REG_THETA     = 3'd3,
    REG_ALPHA     = 3'd4,
    REG_BETA      = 3'd5,
    REG_DELTA     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // clip a 33-bit exact sum to 32 bits
  function automatic sat_t sat_sum(input logic signed [DATA_W:0] v);
    sat_t r;
    r.clip = (v[DATA_W] != v[DATA_W-1]);
    if (r.clip) begin
      r.val = v[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_t add_sat(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return sat_sum(s);
  endfunction

  function automatic sat_t sub_sat(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    return sat_sum(s);
  endfunction

  function automatic sat_t neg_sat(input logic signed [DATA_W-1:0] a);
    logic signed [DATA_W:0] s;
    s = '0 - {a[DATA_W-1], a};
    return sat_sum(s);
  endfunction

  // product >> 30 (floor), clipped to 32 bits
  function automatic sat_t q_finish(input logic signed [PROD_W-1:0] p);
    sat_t r;
    r.clip = !((p[PROD_W-1:PROD_W-3] == 3'b000) || (p[PROD_W-1:PROD_W-3] == 3'b111));
    if (r.clip) begin
      r.val = p[PROD_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = p[Q_FRAC+DATA_W-1:Q_FRAC];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fdtd_efield_update_time_filter.sv
// ----------------------------------------------------------------------------
// fdtd_efield_update_time_filter
// Per-cell electric field advance with Friedman time filter, Q16.16 data and
// Q2.30 coefficients, as an eleven-stage stream pipeline.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The pipeline takes a new cell every cycle while
// the output side is not stalled, and each beat leaves in the order it
// entered. Every stage has its own valid bit and only holds while the stage
// ahead of it is full and stalled, so bubbles close up and in_stall rises only
// when all eleven stages hold beats. The stage count comes from two 32x32
// multiply rounds (current and curl terms, then the filter terms), each
// followed by a stage that scales and clips, plus the chain of saturating
// adds around them. Coefficient registers sit on an APB-style port (byte
// address 4*index, pready tied high); write them only while the pipeline is
// empty. The saturated flag of a result is set when any sum, difference or
// scaled product on that cell's path clipped to 32 bits.
`default_nettype none

module fdtd_efield_update_time_filter
  import fdtdef_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic      [DATA_W-1:0]        prdata,
  output logic                          pready,
  // input beats
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_kind,
  input  wire logic signed [DATA_W-1:0] in_current,
  input  wire logic signed [DATA_W-1:0] in_field_old,
  input  wire logic signed [DATA_W-1:0] in_hist_one,
  input  wire logic signed [DATA_W-1:0] in_hist_two,
  input  wire logic signed [DATA_W-1:0] in_mag_a_here,
  input  wire logic signed [DATA_W-1:0] in_mag_a_next,
  input  wire logic signed [DATA_W-1:0] in_mag_b_here,
  input  wire logic signed [DATA_W-1:0] in_mag_b_next,
  // result beats
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_field_new,
  output logic signed [DATA_W-1:0]      out_field_filtered,
  output logic signed [DATA_W-1:0]      out_hist_one_new,
  output logic signed [DATA_W-1:0]      out_hist_two_new,
  output logic                          out_saturated
);

  // --------------------------------------------------------------------------
  // Coefficient registers
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0]  dt_r, dx_r, dy_r, alpha_r, beta_r, delta_r;
  logic        [THETA_W-1:0] theta_r;
  reg_idx_t                  cfg_idx;
  logic                      cfg_wr;

  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r    <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
      theta_r <= '0;
      alpha_r <= ALPHA_RST;
      beta_r  <= '0;
      delta_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TIME_STEP: dt_r    <= pwdata;
        REG_STEP_DX:   dx_r    <= pwdata;
        REG_STEP_DY:   dy_r    <= pwdata;
        REG_THETA:     theta_r <= pwdata[THETA_W-1:0];
        REG_ALPHA:     alpha_r <= pwdata;
        REG_BETA:      beta_r  <= pwdata;
        REG_DELTA:     delta_r <= pwdata;
        default: ;  // no register there
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TIME_STEP: prdata = dt_r;
      REG_STEP_DX:   prdata = dx_r;
      REG_STEP_DY:   prdata = dy_r;
      REG_THETA:     prdata = {{(DATA_W-THETA_W){1'b0}}, theta_r};
      REG_ALPHA:     prdata = alpha_r;
      REG_BETA:      prdata = beta_r;
      REG_DELTA:     prdata = delta_r;
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] load;

  always_comb begin
    load[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !vld_r[k] || load[k+1];
    end
  end

  assign in_stall  = !load[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (load[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (load[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage payloads
  // --------------------------------------------------------------------------
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // curl differences
  typedef struct packed {
    kind_t kind;
    word_t cur, old, h1, h2, da, db;
    logic  clip;
  } st1_t;

  // raw products, first round
  typedef struct packed {
    kind_t kind;
    word_t old, h1;
    prod_t pj, pa, pb, pt;
    logic  clip;
  } st2_t;

  // scaled products
  typedef struct packed {
    kind_t kind;
    word_t old, h1, qj, qa, qb, qt;
    logic  clip;
  } st3_t;

  // negated current term, history sums
  typedef struct packed {
    kind_t kind;
    word_t old, nj, qa, qb, hsum, h2n;
    logic  clip;
  } st4_t;

  // first curl term added
  typedef struct packed {
    kind_t kind;
    word_t old, tmp, qb, hsum, h2n;
    logic  clip;
  } st5_t;

  // increment done
  typedef struct packed {
    word_t old, adv, hsum, h2n;
    logic  clip;
  } st6_t;

  // new field
  typedef struct packed {
    word_t fnew, adv, hsum, h2n;
    logic  clip;
  } st7_t;

  // raw products, filter round
  typedef struct packed {
    word_t fnew, h1n, h2n;
    prod_t pa, pb, pd;
    logic  clip;
  } st8_t;

  typedef struct packed {
    word_t fnew, h1n, h2n, qa, qb, qd;
    logic  clip;
  } st9_t;

  typedef struct packed {
    word_t fnew, h1n, h2n, f1, qd;
    logic  clip;
  } st10_t;

  typedef struct packed {
    word_t fnew, filt, h1n, h2n;
    logic  clip;
  } st11_t;

  st1_t  s1_r, s1_nxt;
  st2_t  s2_r, s2_nxt;
  st3_t  s3_r, s3_nxt;
  st4_t  s4_r, s4_nxt;
  st5_t  s5_r, s5_nxt;
  st6_t  s6_r, s6_nxt;
  st7_t  s7_r, s7_nxt;
  st8_t  s8_r, s8_nxt;
  st9_t  s9_r, s9_nxt;
  st10_t s10_r, s10_nxt;
  st11_t s11_r, s11_nxt;

  // stage 1: magnetic differences; Bx terms only count for Ez
  sat_t da_s, db_s;
  always_comb begin
    da_s = sub_sat(in_mag_a_next, in_mag_a_here);
    db_s = sub_sat(in_mag_b_next, in_mag_b_here);
    s1_nxt.kind = kind_t'(in_kind);
    s1_nxt.cur  = in_current;
    s1_nxt.old  = in_field_old;
    s1_nxt.h1   = in_hist_one;
    s1_nxt.h2   = in_hist_two;
    s1_nxt.da   = da_s.val;
    s1_nxt.db   = db_s.val;
    s1_nxt.clip = ((s1_nxt.kind != KIND_NONE) && da_s.clip) ||
                  ((s1_nxt.kind == KIND_EZ) && db_s.clip);
  end

  // stage 2: dt*J, curl products, theta*h2
  word_t coef_a;
  word_t theta_s;
  always_comb begin
    coef_a  = (s1_r.kind == KIND_EX) ? dy_r : dx_r;
    theta_s = $signed({1'b0, theta_r});
    s2_nxt.kind = s1_r.kind;
    s2_nxt.old  = s1_r.old;
    s2_nxt.h1   = s1_r.h1;
    s2_nxt.pj   = prod_t'(dt_r) * prod_t'(s1_r.cur);
    s2_nxt.pa   = prod_t'(coef_a) * prod_t'(s1_r.da);
    s2_nxt.pb   = prod_t'(dy_r) * prod_t'(s1_r.db);
    s2_nxt.pt   = prod_t'(theta_s) * prod_t'(s1_r.h2);
    s2_nxt.clip = s1_r.clip;
  end

  // stage 3: scale and clip; unused curl products do not flag
  sat_t qj_s, qa_s, qb_s, qt_s;
  always_comb begin
    qj_s = q_finish(s2_r.pj);
    qa_s = q_finish(s2_r.pa);
    qb_s = q_finish(s2_r.pb);
    qt_s = q_finish(s2_r.pt);
    s3_nxt.kind = s2_r.kind;
    s3_nxt.old  = s2_r.old;
    s3_nxt.h1   = s2_r.h1;
    s3_nxt.qj   = qj_s.val;
    s3_nxt.qa   = qa_s.val;
    s3_nxt.qb   = qb_s.val;
    s3_nxt.qt   = qt_s.val;
    s3_nxt.clip = s2_r.clip || qj_s.clip || qt_s.clip ||
                  ((s2_r.kind != KIND_NONE) && qa_s.clip) ||
                  ((s2_r.kind == KIND_EZ) && qb_s.clip);
  end

  // stage 4: -(dt*J), h1 +/- theta*h2
  sat_t nj_s, hs_s, h2n_s;
  always_comb begin
    nj_s  = neg_sat(s3_r.qj);
    hs_s  = add_sat(s3_r.h1, s3_r.qt);
    h2n_s = sub_sat(s3_r.h1, s3_r.qt);
    s4_nxt.kind = s3_r.kind;
    s4_nxt.old  = s3_r.old;
    s4_nxt.nj   = nj_s.val;
    s4_nxt.qa   = s3_r.qa;
    s4_nxt.qb   = s3_r.qb;
    s4_nxt.hsum = hs_s.val;
    s4_nxt.h2n  = h2n_s.val;
    s4_nxt.clip = s3_r.clip || nj_s.clip || hs_s.clip || h2n_s.clip;
  end

  // stage 5: first curl term, sign per component
  sat_t t_s;
  always_comb begin
    case (s4_r.kind)
      KIND_EX, KIND_EZ: t_s = add_sat(s4_r.nj, s4_r.qa);
      KIND_EY:          t_s = sub_sat(s4_r.nj, s4_r.qa);
      default:          t_s = '{clip: 1'b0, val: s4_r.nj};
    endcase
    s5_nxt.kind = s4_r.kind;
    s5_nxt.old  = s4_r.old;
    s5_nxt.tmp  = t_s.val;
    s5_nxt.qb   = s4_r.qb;
    s5_nxt.hsum = s4_r.hsum;
    s5_nxt.h2n  = s4_r.h2n;
    s5_nxt.clip = s4_r.clip || t_s.clip;
  end

  // stage 6: second curl term, Ez only
  sat_t adv_s;
  always_comb begin
    if (s5_r.kind == KIND_EZ) begin
      adv_s = sub_sat(s5_r.tmp, s5_r.qb);
    end else begin
      adv_s = '{clip: 1'b0, val: s5_r.tmp};
    end
    s6_nxt.old  = s5_r.old;
    s6_nxt.adv  = adv_s.val;
    s6_nxt.hsum = s5_r.hsum;
    s6_nxt.h2n  = s5_r.h2n;
    s6_nxt.clip = s5_r.clip || adv_s.clip;
  end

  // stage 7: advance
  sat_t fnew_s;
  always_comb begin
    fnew_s = add_sat(s6_r.old, s6_r.adv);
    s7_nxt.fnew = fnew_s.val;
    s7_nxt.adv  = s6_r.adv;
    s7_nxt.hsum = s6_r.hsum;
    s7_nxt.h2n  = s6_r.h2n;
    s7_nxt.clip = s6_r.clip || fnew_s.clip;
  end

  // stage 8: filter products, first history
  sat_t h1n_s;
  always_comb begin
    h1n_s = sub_sat(s7_r.fnew, s7_r.adv);
    s8_nxt.fnew = s7_r.fnew;
    s8_nxt.h1n  = h1n_s.val;
    s8_nxt.h2n  = s7_r.h2n;
    s8_nxt.pa   = prod_t'(alpha_r) * prod_t'(s7_r.fnew);
    s8_nxt.pb   = prod_t'(beta_r) * prod_t'(s7_r.adv);
    s8_nxt.pd   = prod_t'(delta_r) * prod_t'(s7_r.hsum);
    s8_nxt.clip = s7_r.clip || h1n_s.clip;
  end

  // stage 9: scale and clip filter products
  sat_t fa_s, fb_s, fd_s;
  always_comb begin
    fa_s = q_finish(s8_r.pa);
    fb_s = q_finish(s8_r.pb);
    fd_s = q_finish(s8_r.pd);
    s9_nxt.fnew = s8_r.fnew;
    s9_nxt.h1n  = s8_r.h1n;
    s9_nxt.h2n  = s8_r.h2n;
    s9_nxt.qa   = fa_s.val;
    s9_nxt.qb   = fb_s.val;
    s9_nxt.qd   = fd_s.val;
    s9_nxt.clip = s8_r.clip || fa_s.clip || fb_s.clip || fd_s.clip;
  end

  // stage 10: alpha*new + beta*adv
  sat_t f1_s;
  always_comb begin
    f1_s = add_sat(s9_r.qa, s9_r.qb);
    s10_nxt.fnew = s9_r.fnew;
    s10_nxt.h1n  = s9_r.h1n;
    s10_nxt.h2n  = s9_r.h2n;
    s10_nxt.f1   = f1_s.val;
    s10_nxt.qd   = s9_r.qd;
    s10_nxt.clip = s9_r.clip || f1_s.clip;
  end

  // stage 11: add the delta term; output register
  sat_t filt_s;
  always_comb begin
    filt_s = add_sat(s10_r.f1, s10_r.qd);
    s11_nxt.fnew = s10_r.fnew;
    s11_nxt.filt = filt_s.val;
    s11_nxt.h1n  = s10_r.h1n;
    s11_nxt.h2n  = s10_r.h2n;
    s11_nxt.clip = s10_r.clip || filt_s.clip;
  end

  always_ff @(posedge clk) begin
    if (load[0])  s1_r  <= s1_nxt;
    if (load[1])  s2_r  <= s2_nxt;
    if (load[2])  s3_r  <= s3_nxt;
    if (load[3])  s4_r  <= s4_nxt;
    if (load[4])  s5_r  <= s5_nxt;
    if (load[5])  s6_r  <= s6_nxt;
    if (load[6])  s7_r  <= s7_nxt;
    if (load[7])  s8_r  <= s8_nxt;
    if (load[8])  s9_r  <= s9_nxt;
    if (load[9])  s10_r <= s10_nxt;
    if (load[10]) s11_r <= s11_nxt;
  end

  assign out_field_new      = s11_r.fnew;
  assign out_field_filtered = s11_r.filt;
  assign out_hist_one_new   = s11_r.h1n;
  assign out_hist_two_new   = s11_r.h2n;
  assign out_saturated      = s11_r.clip;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with an empty stage");

  a_accept_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat not in first stage");

  a_bubble_closes : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && !vld_r[NSTG-1]) |=> vld_r[NSTG-1])
    else $error("beat did not move into empty output stage");

  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !load[1]) |=> vld_r[0])
    else $error("held beat lost in first stage");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - fdtd_efield_update_time_filter
// Streams grid cells through the field update with time filter and checks
// every result beat against hand-typed values or a fixed-point predictor. Coefficients
// are reloaded over the APB port between phases (extremes, zero, physically
// coherent sets, random words) and read back. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import fdtdef_pkg::*;
();

  // cycles without any handshake before the run is declared hung
  localparam int IDLE_LIMIT = 5000;
  localparam int REG_COUNT  = 7;     // REG_TIME_STEP .. REG_DELTA
  localparam int RAND_CELLS = 100;   // cells per random phase

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] current, field_old, hist_one, hist_two;
    logic signed [DATA_W-1:0] a_here, a_next, b_here, b_next;
  } grid_cell_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] field_new, field_filtered;
    logic signed [DATA_W-1:0] hist_one_new, hist_two_new;
    logic                     saturated;
  } cell_result_t;

  typedef struct {
    bit           fixed_result;   // want typed in by hand (reset coefficients)
    grid_cell_t   beat;
    cell_result_t want;
  } dir_row_t;

  typedef enum {COEF_ZERO, COEF_MIN, COEF_MAX, COEF_PHYS, COEF_WILD} coef_set_t;
  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_HEAVY} sink_mode_t;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall, out_saturated;
  logic [1:0] in_kind;
  logic signed [DATA_W-1:0] in_current, in_field_old, in_hist_one, in_hist_two;
  logic signed [DATA_W-1:0] in_mag_a_here, in_mag_a_next, in_mag_b_here, in_mag_b_next;
  logic signed [DATA_W-1:0] out_field_new, out_field_filtered;
  logic signed [DATA_W-1:0] out_hist_one_new, out_hist_two_new;

  fdtd_efield_update_time_filter dut (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_kind, .in_current, .in_field_old,
    .in_hist_one, .in_hist_two, .in_mag_a_here, .in_mag_a_next,
    .in_mag_b_here, .in_mag_b_next,
    .out_valid, .out_stall, .out_field_new, .out_field_filtered,
    .out_hist_one_new, .out_hist_two_new, .out_saturated
  );

  // Shadow copy of the coefficient registers, as they read back. theta keeps
  // only its low 31 bits.
  logic [DATA_W-1:0] coef_image [REG_COUNT];

  cell_result_t results_due[$];   // predicted beats, oldest first
  int  mismatches = 0;
  int  cells_sent = 0;
  int  clipped_cells = 0;
  int  coef_loads = 0;
  int  kinds_sent [4] = '{0, 0, 0, 0};
  int  burst_left = 1;
  int  gap_left = 0;
  bit  clip_hit;

  // Directed cells. The first four run on reset coefficients (dt and curl
  // coefficients zero, alpha one, beta and delta zero), so the increment is
  // zero and the results can be read off directly; the clip flag still
  // fires on a clipped curl difference even though its coefficient is zero.
  dir_row_t directed_rows [14] = '{
    '{1'b1, '{KIND_EX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX,
              SAT_MIN, SAT_MAX, 32'sd0, 32'sd0},
            '{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, 1'b1}},
    '{1'b1, '{KIND_EY, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN,
              32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, 1'b0}},
    '{1'b1, '{KIND_EZ, 32'sh0000_4000, 32'sh0001_8000, -32'sd1, 32'sh1234_5678,
              32'sd3, 32'sd5, 32'sd1, SAT_MIN},
            '{32'sh0001_8000, 32'sh0001_8000, 32'sh0001_8000, -32'sd1, 1'b1}},
    // unused kind code: all four magnetic inputs ignored, no clip from them
    '{1'b1, '{KIND_NONE, SAT_MAX, -32'sd1, 32'sd1, -32'sd1,
              SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN},
            '{-32'sd1, -32'sd1, -32'sd1, 32'sd1, 1'b0}},
    // the rest go through the predictor under loaded coefficients
    '{1'b0, '{KIND_EX, 32'sh0000_2000, 32'sh0003_0000, 32'sh0002_8000, -32'sh0001_0000,
              32'sh0001_0000, 32'sh0001_4000, 32'sh7000_0000, SAT_MIN}, '0},
    '{1'b0, '{KIND_EY, -32'sh0000_3000, -32'sh0003_0000, 32'sh0000_1000, 32'sh0000_8000,
              32'sh0002_0000, -32'sh0000_4000, 32'sd0, 32'sd0}, '0},
    '{1'b0, '{KIND_EZ, 32'sh0000_0100, 32'sh0000_4000, -32'sh0000_4000, 32'sh0001_0000,
              32'sh0000_1000, 32'sh0000_3000, 32'sh0000_2000, -32'sh0000_1000}, '0},
    '{1'b0, '{KIND_NONE, 32'sh0001_0000, 32'sh0000_8000, 32'sh0000_4000, 32'sh0000_2000,
              SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN}, '0},
    '{1'b0, '{KIND_EY, SAT_MIN, 32'sd0, 32'sd0, 32'sd0,
              32'sd0, 32'sd1, 32'sd0, 32'sd0}, '0},
    '{1'b0, '{KIND_EZ, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
              SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX}, '0},
    '{1'b0, '{KIND_EZ, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
              SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN}, '0},
    '{1'b0, '{KIND_EX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX,
              SAT_MIN, SAT_MAX, 32'sd0, 32'sd0}, '0},
    '{1'b0, '{KIND_EY, 32'sd0, 32'sd0, SAT_MAX, SAT_MIN,
              SAT_MAX, SAT_MIN, 32'sd0, 32'sd0}, '0},
    '{1'b0, '{KIND_EX, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
              32'sd0, 32'sd0, 32'sd0, 32'sd0}, '0}
  };

  coef_set_t phase_sets [11] = '{COEF_MIN, COEF_ZERO, COEF_PHYS, COEF_WILD, COEF_PHYS,
                                 COEF_MAX, COEF_PHYS, COEF_WILD, COEF_PHYS, COEF_WILD,
                                 COEF_PHYS};

  // -------------------------------------------------------------------------
  // Fixed-point predictor
  // -------------------------------------------------------------------------

  // clip to 32 bits signed, remembering that it happened
  function automatic longint clip32(input longint v);
    if (v > longint'(SAT_MAX)) begin
      clip_hit = 1'b1;
      return longint'(SAT_MAX);
    end
    if (v < longint'(SAT_MIN)) begin
      clip_hit = 1'b1;
      return longint'(SAT_MIN);
    end
    return v;
  endfunction

  // Q2.30 coefficient times Q16.16 value: floor shift, then clip
  function automatic longint q30_mul(input longint coef, input longint x);
    return clip32((coef * x) >>> Q_FRAC);
  endfunction

  function automatic cell_result_t cell_update(input grid_cell_t c);
    longint dt, kx, ky, th, al, be, de;
    longint cur, old, h1, h2, ah, an, bh, bn;
    longint adv, fnew, th2, filt;
    cell_result_t r;
    dt  = longint'(signed'(coef_image[REG_TIME_STEP]));
    kx  = longint'(signed'(coef_image[REG_STEP_DX]));
    ky  = longint'(signed'(coef_image[REG_STEP_DY]));
    th  = longint'(coef_image[REG_THETA]);
    al  = longint'(signed'(coef_image[REG_ALPHA]));
    be  = longint'(signed'(coef_image[REG_BETA]));
    de  = longint'(signed'(coef_image[REG_DELTA]));
    cur = longint'(c.current);
    old = longint'(c.field_old);
    h1  = longint'(c.hist_one);
    h2  = longint'(c.hist_two);
    ah  = longint'(c.a_here);
    an  = longint'(c.a_next);
    bh  = longint'(c.b_here);
    bn  = longint'(c.b_next);
    clip_hit = 1'b0;

    // increment: current term, then the curl of this component
    adv = clip32(-q30_mul(dt, cur));
    case (c.kind)
      KIND_EX: adv = clip32(adv + q30_mul(ky, clip32(an - ah)));
      KIND_EY: adv = clip32(adv - q30_mul(kx, clip32(an - ah)));
      KIND_EZ: begin
        adv = clip32(adv + q30_mul(kx, clip32(an - ah)));
        adv = clip32(adv - q30_mul(ky, clip32(bn - bh)));
      end
      default: ;
    endcase

    fnew = clip32(old + adv);
    th2  = q30_mul(th, h2);
    filt = clip32(q30_mul(al, fnew) + q30_mul(be, adv));
    filt = clip32(filt + q30_mul(de, clip32(h1 + th2)));

    r.field_new      = 32'(fnew);
    r.field_filtered = 32'(filt);
    r.hist_two_new   = 32'(clip32(h1 - th2));
    r.hist_one_new   = 32'(clip32(fnew - adv));
    r.saturated      = clip_hit;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Clock, result sink, watchdog, result check
  // -------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern: modes of random length, from never stalling to
  // stalling with a chance of three in four.
  initial begin : result_sink
    sink_mode_t mode;
    int left, tick;
    mode = SINK_OPEN;
    left = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 150);
      end
      left--;
      tick++;
      case (mode)
        SINK_OPEN:     out_stall <= 1'b0;
        SINK_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        SINK_PERIODIC: out_stall <= ((tick % 5) >= 3);
        default:       out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // any beat, either channel, or a register access counts as progress
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no beat for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, results_due.size());
    $display("fdtd_efield_update_time_filter verification failed");
    $finish;
  end

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected, field_new %h",
                 $time, out_field_new);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("field_new", want.field_new, out_field_new);
        check_field("field_filtered", want.field_filtered, out_field_filtered);
        check_field("hist_one_new", want.hist_one_new, out_hist_one_new);
        check_field("hist_two_new", want.hist_two_new, out_hist_two_new);
        check_field("saturated", 32'(want.saturated), 32'(out_saturated));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Drivers. Every task starts and returns just after a falling edge at
  // which it has not driven anything yet.
  // -------------------------------------------------------------------------

  task automatic apb_access(input bit wr, input int idx, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_regs();
    logic [DATA_W-1:0] rd;
    for (int i = 0; i < REG_COUNT; i++) begin
      apb_access(1'b0, i, $urandom, rd);
      if (rd !== coef_image[i]) begin
        $display("%0t: register %0d reads %h, expected %h", $time, i, rd, coef_image[i]);
        mismatches++;
      end
    end
  endtask

  // Load a coefficient set. Also writes one address past the map, which the
  // block must ignore; the read back afterwards shows it did.
  task automatic load_coefs(input coef_set_t set);
    logic [DATA_W-1:0] val [REG_COUNT + 1];
    logic [DATA_W-1:0] rd;
    real th;
    for (int i = 0; i <= REG_COUNT; i++) begin
      case (set)
        COEF_ZERO: val[i] = '0;
        COEF_MIN:  val[i] = SAT_MIN;   // theta drops bit 31 here, reads 0
        COEF_MAX:  val[i] = SAT_MAX;   // theta near two: above one on purpose
        default:   val[i] = $urandom;
      endcase
    end
    if (set == COEF_PHYS) begin
      // small steps, theta in [0, 1] and alpha/beta/delta derived from it
      val[REG_TIME_STEP] = $urandom_range(0, 32'h2000_0000);
      val[REG_STEP_DX]   = $urandom_range(0, 32'h2000_0000);
      val[REG_STEP_DY]   = $urandom_range(0, 32'h2000_0000);
      val[REG_THETA]     = $urandom_range(0, 32'h4000_0000);
      th = real'(val[REG_THETA]) / 1073741824.0;
      val[REG_ALPHA] = 32'($rtoi((1.0 - th / 2.0 + th * th / 2.0) * 1073741824.0));
      val[REG_BETA]  = 32'($rtoi(th * (1.0 - th / 2.0) * 1073741824.0));
      val[REG_DELTA] = 32'($rtoi(th * (1.0 - th) * (1.0 - th) / 2.0 * 1073741824.0));
    end
    for (int i = 0; i <= REG_COUNT; i++) begin
      apb_access(1'b1, i, val[i], rd);
      if (i == REG_THETA)
        coef_image[i] = {1'b0, val[i][THETA_W-1:0]};
      else if (i < REG_COUNT)
        coef_image[i] = val[i];
    end
    check_regs();
    coef_loads++;
  endtask

  // Send one cell beat in bursts with gaps; the prediction is queued at the
  // edge that accepts the beat.
  task automatic push_cell(input grid_cell_t c, input cell_result_t want);
    while (gap_left > 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
      gap_left--;
    end
    in_valid      <= 1'b1;
    in_kind       <= c.kind;
    in_current    <= c.current;
    in_field_old  <= c.field_old;
    in_hist_one   <= c.hist_one;
    in_hist_two   <= c.hist_two;
    in_mag_a_here <= c.a_here;
    in_mag_a_next <= c.a_next;
    in_mag_b_here <= c.b_here;
    in_mag_b_next <= c.b_next;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(want);
    cells_sent++;
    kinds_sent[c.kind]++;
    if (want.saturated) clipped_cells++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      // mostly short bursts, now and then a long back-to-back stretch
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 8);
      gap_left   = $urandom_range(0, 6);
    end
  endtask

  // drop valid and wait for every predicted beat to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  task automatic walk_rows(input bit fixed_pass);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].fixed_result == fixed_pass)
        push_cell(directed_rows[i].beat,
                  fixed_pass ? directed_rows[i].want : cell_update(directed_rows[i].beat));
    end
    drain();
  endtask

  // Q16.16 operand: mostly modest magnitudes, some full-range words, some
  // extremes and values around zero
  function automatic logic [DATA_W-1:0] pick_word();
    logic [DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {{12{w[19]}}, w[19:0]};
      5, 6:          return w;
      7:             return SAT_MAX;
      8:             return SAT_MIN;
      default:       return 32'($urandom_range(0, 2)) - 32'd1;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------

  initial begin : stimulus
    grid_cell_t c;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_kind = '0;
    in_current = '0;
    in_field_old = '0;
    in_hist_one = '0;
    in_hist_two = '0;
    in_mag_a_here = '0;
    in_mag_a_next = '0;
    in_mag_b_here = '0;
    in_mag_b_next = '0;
    coef_image = '{32'd0, 32'd0, 32'd0, 32'd0, ALPHA_RST, 32'd0, 32'd0};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values of the map, then hand-checked cells on them
    check_regs();
    walk_rows(1'b1);

    // the other directed cells under a coherent set and under the top extremes
    load_coefs(COEF_PHYS);
    walk_rows(1'b0);
    load_coefs(COEF_MAX);
    walk_rows(1'b0);

    // random cells, one coefficient set per phase
    foreach (phase_sets[p]) begin
      load_coefs(phase_sets[p]);
      repeat (RAND_CELLS) begin
        c.kind      = ($urandom_range(0, 9) == 0) ? KIND_NONE : kind_t'($urandom_range(0, 2));
        c.current   = pick_word();
        c.field_old = pick_word();
        c.hist_one  = pick_word();
        c.hist_two  = pick_word();
        c.a_here    = pick_word();
        c.a_next    = pick_word();
        c.b_here    = pick_word();
        c.b_next    = pick_word();
        push_cell(c, cell_update(c));
      end
      drain();
    end

    // nothing may trail the last expected beat
    repeat (2 * NSTG) @(negedge clk);

    $display("%0d cells (Ex %0d, Ey %0d, Ez %0d, unused kind %0d) over %0d coefficient loads",
             cells_sent, kinds_sent[KIND_EX], kinds_sent[KIND_EY], kinds_sent[KIND_EZ],
             kinds_sent[KIND_NONE], coef_loads);
    $display("%0d cells clipped somewhere on their path, %0d mismatches",
             clipped_cells, mismatches);
    if (mismatches == 0)
      $display("fdtd_efield_update_time_filter verification clean");
    else
      $display("fdtd_efield_update_time_filter verification failed");
    $finish;
  end

endmodule

`default_nettype wire
